### rtl/i2cram_pkg.sv
package i2cram_pkg;

   // action codes carried on the request tuser
   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_WRITE = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   // device address after reset (write form, read bit zero)
   localparam logic [7:0] DEV_ADDR_RESET = 8'd174;

   // request beat fields
   typedef struct packed {
      logic [1:0] action;
      logic [7:0] register_address;
      logic [7:0] write_data;
      logic       sda_in;
   } req_type;

   // result beat fields
   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       busy_res;
      logic       done_res;
      logic       success;
      logic [7:0] read_byte;
   } rsp_type;

endpackage

### rtl/i2cram_seq.sv
module i2cram_seq (
   input  logic               clock,
   input  logic               reset,
   input  logic               step_en,
   input  i2cram_pkg::req_type req,
   input  logic [7:0]         device_address,
   output i2cram_pkg::rsp_type rsp
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_START, ST_ADDR_W, ST_ACK_ADDR_W, ST_REG, ST_ACK_REG,
      ST_DATA, ST_ACK_DATA, ST_RESTART, ST_ADDR_R, ST_ACK_ADDR_R, ST_RECV,
      ST_NACK, ST_STOP
   } stage_type;

   stage_type  stage_ff, stage_in, cur_stage;
   logic [2:0] bit_ff, bit_in, cur_bit;
   logic [1:0] sub_ff, sub_in, cur_sub;
   logic [7:0] shift_ff, shift_in, cur_shift;
   logic       is_read_ff, is_read_in;
   logic [7:0] reg_addr_ff, reg_addr_in;
   logic [7:0] wdata_ff, wdata_in;
   logic       scl_ff, scl_in;
   logic       sda_ff, sda_in;
   logic       start;
   logic       done;
   logic       ok;
   logic [7:0] rbyte;

   // pick up a new transaction only while idle
   always_comb begin
      start = (stage_ff == ST_IDLE) &&
              ((req.action == i2cram_pkg::ACT_WRITE) ||
               (req.action == i2cram_pkg::ACT_READ));
      cur_stage   = start ? ST_START : stage_ff;
      cur_sub     = start ? 2'd0 : sub_ff;
      cur_bit     = start ? 3'd0 : bit_ff;
      cur_shift   = start ? 8'd0 : shift_ff;
      reg_addr_in = start ? req.register_address : reg_addr_ff;
      wdata_in    = start ? req.write_data : wdata_ff;
      is_read_in  = start ? (req.action == i2cram_pkg::ACT_READ) : is_read_ff;
   end

   // advance one bus phase
   always_comb begin
      stage_in = cur_stage;
      sub_in   = cur_sub;
      bit_in   = cur_bit;
      shift_in = cur_shift;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      done     = 1'b0;
      ok       = 1'b0;
      rbyte    = 8'd0;
      unique case (cur_stage)
         ST_START, ST_RESTART: begin
            case (cur_sub)
               2'd0: begin
                  scl_in = 1'b1; sda_in = 1'b1; sub_in = 2'd1;
               end
               2'd1: begin
                  scl_in = 1'b1; sda_in = 1'b0; sub_in = 2'd2;
               end
               default: begin
                  scl_in = 1'b0; sda_in = 1'b0;
                  sub_in = 2'd0; bit_in = 3'd0;
                  if (cur_stage == ST_START) begin
                     stage_in = ST_ADDR_W;
                     shift_in = device_address;
                  end else begin
                     stage_in = ST_ADDR_R;
                     shift_in = device_address + 8'd1;
                  end
               end
            endcase
         end
         ST_ADDR_W, ST_REG, ST_DATA, ST_ADDR_R: begin
            sda_in = cur_shift[7];
            case (cur_sub)
               2'd0: begin
                  scl_in = 1'b0; sub_in = 2'd1;
               end
               2'd1: begin
                  scl_in = 1'b1; sub_in = 2'd2;
               end
               default: begin
                  scl_in   = 1'b0;
                  shift_in = {cur_shift[6:0], 1'b0};
                  sub_in   = 2'd0;
                  if (cur_bit == 3'd7) begin
                     bit_in = 3'd0;
                     case (cur_stage)
                        ST_ADDR_W: stage_in = ST_ACK_ADDR_W;
                        ST_REG:    stage_in = ST_ACK_REG;
                        ST_DATA:   stage_in = ST_ACK_DATA;
                        default:   stage_in = ST_ACK_ADDR_R;
                     endcase
                  end else begin
                     bit_in = cur_bit + 3'd1;
                  end
               end
            endcase
         end
         ST_ACK_ADDR_W, ST_ACK_REG, ST_ACK_DATA, ST_ACK_ADDR_R: begin
            sda_in = 1'b1;
            case (cur_sub)
               2'd0: begin
                  scl_in = 1'b0; sub_in = 2'd1;
               end
               2'd1: begin
                  scl_in = 1'b1; sub_in = 2'd2;
               end
               default: begin
                  scl_in   = 1'b0;
                  sub_in   = 2'd0;
                  bit_in   = 3'd0;
                  shift_in = 8'd0;
                  if (req.sda_in) begin
                     // device did not acknowledge: fail, no stop
                     done     = 1'b1;
                     stage_in = ST_IDLE;
                  end else begin
                     case (cur_stage)
                        ST_ACK_ADDR_W: begin
                           stage_in = ST_REG;
                           shift_in = reg_addr_in;
                        end
                        ST_ACK_REG: begin
                           if (is_read_in) begin
                              stage_in = ST_RESTART;
                           end else begin
                              stage_in = ST_DATA;
                              shift_in = wdata_in;
                           end
                        end
                        ST_ACK_DATA: stage_in = ST_STOP;
                        default:     stage_in = ST_RECV;
                     endcase
                  end
               end
            endcase
         end
         ST_RECV: begin
            sda_in = 1'b1;
            if (cur_sub == 2'd0) begin
               scl_in = 1'b1; sub_in = 2'd1;
            end else begin
               scl_in   = 1'b0;
               shift_in = {cur_shift[6:0], req.sda_in};
               sub_in   = 2'd0;
               if (cur_bit == 3'd7) begin
                  bit_in   = 3'd0;
                  stage_in = ST_NACK;
               end else begin
                  bit_in = cur_bit + 3'd1;
               end
            end
         end
         ST_NACK: begin
            sda_in = 1'b1;
            case (cur_sub)
               2'd0: begin
                  scl_in = 1'b0; sub_in = 2'd1;
               end
               2'd1: begin
                  scl_in = 1'b1; sub_in = 2'd2;
               end
               default: begin
                  scl_in   = 1'b0;
                  stage_in = ST_STOP;
                  sub_in   = 2'd0;
                  bit_in   = 3'd0;
               end
            endcase
         end
         ST_STOP: begin
            scl_in = 1'b1;
            if (cur_sub == 2'd0) begin
               sda_in = 1'b0; sub_in = 2'd1;
            end else begin
               sda_in   = 1'b1;
               done     = 1'b1;
               ok       = 1'b1;
               rbyte    = is_read_in ? cur_shift : 8'd0;
               stage_in = ST_IDLE;
               sub_in   = 2'd0;
               bit_in   = 3'd0;
            end
         end
         default: begin
            stage_in = ST_IDLE;
            sub_in   = 2'd0;
            bit_in   = 3'd0;
         end
      endcase
   end

   // result of this beat, before registering
   always_comb begin
      rsp.scl_level = scl_in;
      rsp.sda_level = sda_in;
      rsp.busy_res  = (stage_in != ST_IDLE);
      rsp.done_res  = done;
      rsp.success   = ok;
      rsp.read_byte = rbyte;
   end

   // hold sequencer state; advance on each accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff    <= ST_IDLE;
         sub_ff      <= 2'd0;
         bit_ff      <= 3'd0;
         shift_ff    <= 8'd0;
         is_read_ff  <= 1'b0;
         reg_addr_ff <= 8'd0;
         wdata_ff    <= 8'd0;
         scl_ff      <= 1'b1;
         sda_ff      <= 1'b1;
      end else if (step_en) begin
         stage_ff    <= stage_in;
         sub_ff      <= sub_in;
         bit_ff      <= bit_in;
         shift_ff    <= shift_in;
         is_read_ff  <= is_read_in;
         reg_addr_ff <= reg_addr_in;
         wdata_ff    <= wdata_in;
         scl_ff      <= scl_in;
         sda_ff      <= sda_in;
      end
   end

endmodule

### rtl/i2c_register_access_master_core.sv
// Channel | Dir | Signals               | Beat contents
// req     | in  | req_tvalid/tready     | tuser[1:0] action; tdata register/data/sda_in
// rsp     | out | rsp_tvalid/tready     | tdata line levels, status, read byte
// csr     | in  | csr_wr_en, csr_wr_data| device address (write form)
//
// One request beat is one bus phase; a beat is accepted every cycle while the
// result register is empty or being drained, so the rate is one beat per cycle.
// Each result is held in the result register and shows in the cycle after its
// request is accepted. Synchronous reset returns the sequencer to idle with both
// lines released and the result register empty. A stalled rsp side holds its
// beat and stops request acceptance until it is taken.
module i2c_register_access_master_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [7:0] register_address, [15:8] write_data,
                                    // [16] sda_in, [23:17] zero
   input  logic [1:0]  req_tuser,   // [1:0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [0] scl_level, [1] sda_level, [2] busy_res,
                                    // [3] done_res, [4] success, [12:5] read_byte,
                                    // [15:13] zero
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   i2cram_pkg::req_type req;
   i2cram_pkg::rsp_type rsp_next;
   i2cram_pkg::rsp_type rsp_ff;
   logic                rsp_valid_ff;
   logic [7:0]          dev_addr_ff;
   logic                accept;

   // unpack the request beat
   always_comb begin
      req.action           = req_tuser;
      req.register_address = req_tdata[7:0];
      req.write_data       = req_tdata[15:8];
      req.sda_in           = req_tdata[16];
   end

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // hold the device address register
   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff <= i2cram_pkg::DEV_ADDR_RESET;
      end else if (csr_wr_en) begin
         dev_addr_ff <= csr_wr_data;
      end
   end

   i2cram_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .step_en        (accept),
      .req            (req),
      .device_address (dev_addr_ff),
      .rsp            (rsp_next)
   );

   // result valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_ff.read_byte, rsp_ff.success, rsp_ff.done_res,
                        rsp_ff.busy_res, rsp_ff.sda_level, rsp_ff.scl_level};

   // a finished transaction is never still busy
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.done_res |-> !rsp_ff.busy_res)
      else $error("done reported while busy");

   // success only comes with done
   a_success_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.success |-> rsp_ff.done_res)
      else $error("success without done");

   // a received byte only shows on a successful finish
   a_rbyte_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.read_byte != 8'd0) |-> rsp_ff.success)
      else $error("read byte outside successful done");

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff)
      else $error("result valid after reset");

endmodule

### tb/tb_i2c_register_access_master_core.sv
module tb_i2c_register_access_master_core;

   timeunit 1ns;
   timeprecision 1ps;

   // action value outside the defined set, must act as a plain tick
   localparam logic [1:0] ACT_SPARE = 2'd3;
   localparam int GAP_MAX = 12;

   // bus sequencer phases as tracked by the predictor
   typedef enum logic [3:0] {
      PH_IDLE, PH_START, PH_DEV_W, PH_ACK_DEV_W, PH_REG, PH_ACK_REG,
      PH_DATA, PH_ACK_DATA, PH_RESTART, PH_DEV_R, PH_ACK_DEV_R, PH_RECV,
      PH_NACK, PH_STOP
   } ph_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata   = '0;
   logic [1:0]  req_tuser   = i2cram_pkg::ACT_TICK;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_wr_en   = 1'b0;
   logic [7:0]  csr_wr_data = '0;

   i2c_register_access_master_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // predictor state
   ph_type     ph        = PH_IDLE;
   logic [2:0] bit_cnt   = '0;
   logic [1:0] sub       = '0;
   logic [7:0] shreg     = '0;
   logic       rd_mode   = 1'b0;
   logic [7:0] reg_hold  = '0;
   logic [7:0] data_hold = '0;
   logic       scl_q     = 1'b1;
   logic       sda_q     = 1'b1;
   logic [7:0] dev_addr_q = i2cram_pkg::DEV_ADDR_RESET;

   i2cram_pkg::rsp_type expected_phase_q[$];

   int beats_sent = 0;
   int rsp_seen   = 0;
   int bad_count  = 0;
   int req_gap_max = GAP_MAX;
   int rsp_gap_max = GAP_MAX;
   int noise_pct   = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // hard stop well past the slowest legal run
   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   task automatic goto_phase(input ph_type nxt, input logic [7:0] load);
      ph = nxt;
      sub = 2'd0;
      bit_cnt = 3'd0;
      shreg = load;
   endtask

   task automatic set_lines(input logic scl, input logic sda);
      scl_q = scl;
      sda_q = sda;
   endtask

   // advance the bus model by one phase and queue the expected beat
   task automatic predict_bus_phase(input i2cram_pkg::req_type it);
      i2cram_pkg::rsp_type r;
      logic    bitv;
      r = '0;
      if (ph == PH_IDLE && (it.action == i2cram_pkg::ACT_WRITE ||
                            it.action == i2cram_pkg::ACT_READ)) begin
         reg_hold  = it.register_address;
         data_hold = it.write_data;
         rd_mode   = (it.action == i2cram_pkg::ACT_READ);
         goto_phase(PH_START, 8'h00);
      end
      case (ph)
         PH_START, PH_RESTART: begin
            if (sub == 2'd0) begin
               set_lines(1'b1, 1'b1);
               sub = 2'd1;
            end else if (sub == 2'd1) begin
               set_lines(1'b1, 1'b0);
               sub = 2'd2;
            end else begin
               set_lines(1'b0, 1'b0);
               if (ph == PH_START) goto_phase(PH_DEV_W, dev_addr_q);
               else goto_phase(PH_DEV_R, dev_addr_q + 8'd1);
            end
         end
         PH_DEV_W, PH_REG, PH_DATA, PH_DEV_R: begin
            bitv = shreg[7];
            if (sub == 2'd0) begin
               set_lines(1'b0, bitv);
               sub = 2'd1;
            end else if (sub == 2'd1) begin
               set_lines(1'b1, bitv);
               sub = 2'd2;
            end else begin
               set_lines(1'b0, bitv);
               shreg = {shreg[6:0], 1'b0};
               sub = 2'd0;
               if (bit_cnt == 3'd7) begin
                  bit_cnt = 3'd0;
                  case (ph)
                     PH_DEV_W: ph = PH_ACK_DEV_W;
                     PH_REG:   ph = PH_ACK_REG;
                     PH_DATA:  ph = PH_ACK_DATA;
                     default:  ph = PH_ACK_DEV_R;
                  endcase
               end else begin
                  bit_cnt = bit_cnt + 3'd1;
               end
            end
         end
         PH_ACK_DEV_W, PH_ACK_REG, PH_ACK_DATA, PH_ACK_DEV_R: begin
            if (sub == 2'd0) begin
               set_lines(1'b0, 1'b1);
               sub = 2'd1;
            end else if (sub == 2'd1) begin
               set_lines(1'b1, 1'b1);
               sub = 2'd2;
            end else begin
               set_lines(1'b0, 1'b1);
               // a released line here is a NACK: abort without stop
               if (it.sda_in) begin
                  r.done_res = 1'b1;
                  goto_phase(PH_IDLE, 8'h00);
               end else begin
                  case (ph)
                     PH_ACK_DEV_W: goto_phase(PH_REG, reg_hold);
                     PH_ACK_REG:
                        if (rd_mode) goto_phase(PH_RESTART, 8'h00);
                        else goto_phase(PH_DATA, data_hold);
                     PH_ACK_DATA: goto_phase(PH_STOP, 8'h00);
                     default:     goto_phase(PH_RECV, 8'h00);
                  endcase
               end
            end
         end
         PH_RECV: begin
            if (sub == 2'd0) begin
               set_lines(1'b1, 1'b1);
               sub = 2'd1;
            end else begin
               set_lines(1'b0, 1'b1);
               shreg = {shreg[6:0], it.sda_in};
               sub = 2'd0;
               if (bit_cnt == 3'd7) begin
                  bit_cnt = 3'd0;
                  ph = PH_NACK;
               end else begin
                  bit_cnt = bit_cnt + 3'd1;
               end
            end
         end
         PH_NACK: begin
            if (sub == 2'd0) begin
               set_lines(1'b0, 1'b1);
               sub = 2'd1;
            end else if (sub == 2'd1) begin
               set_lines(1'b1, 1'b1);
               sub = 2'd2;
            end else begin
               set_lines(1'b0, 1'b1);
               ph = PH_STOP;
               sub = 2'd0;
               bit_cnt = 3'd0;
            end
         end
         PH_STOP: begin
            if (sub == 2'd0) begin
               set_lines(1'b1, 1'b0);
               sub = 2'd1;
            end else begin
               set_lines(1'b1, 1'b1);
               r.done_res  = 1'b1;
               r.success   = 1'b1;
               r.read_byte = rd_mode ? shreg : 8'h00;
               ph = PH_IDLE;
               sub = 2'd0;
               bit_cnt = 3'd0;
            end
         end
         default: begin
            ph = PH_IDLE;
            sub = 2'd0;
            bit_cnt = 3'd0;
         end
      endcase
      r.scl_level = scl_q;
      r.sda_level = sda_q;
      r.busy_res  = (ph != PH_IDLE);
      expected_phase_q.push_back(r);
   endtask

   // ---------------------------------------------------------------- stimulus

   // send one request beat after a random hold-off
   task automatic send_beat(input logic [1:0] act, input logic [7:0] ra,
                            input logic [7:0] wd, input logic sda);
      int      gap;
      i2cram_pkg::req_type it;
      gap = (req_gap_max > 0) ? $urandom_range(0, req_gap_max) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, sda, wd, ra};
      req_tuser  <= act;
      do @(posedge clock); while (!req_tready);
      it.action = act;
      it.register_address = ra;
      it.write_data = wd;
      it.sda_in = sda;
      predict_bus_phase(it);
      beats_sent++;
   endtask

   // pick the device's answer on the line for the next phase
   function automatic logic device_sda(input ph_type nack_at);
      if (sub == 2'd2 &&
          ph inside {PH_ACK_DEV_W, PH_ACK_REG, PH_ACK_DATA, PH_ACK_DEV_R}) begin
         if (ph == nack_at) return 1'b1;
         if (noise_pct > 0 && $urandom_range(0, 99) < noise_pct) return 1'b1;
         return 1'b0;
      end
      return 1'($urandom_range(0, 1));
   endfunction

   // one phase of a running frame, with a random (ignored) action
   task automatic tick_busy(input ph_type nack_at);
      send_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), device_sda(nack_at));
   endtask

   // start a frame and clock it through to completion
   task automatic run_frame(input logic [1:0] act, input logic [7:0] ra,
                            input logic [7:0] wd, input ph_type nack_at);
      send_beat(act, ra, wd, 1'($urandom_range(0, 1)));
      while (ph != PH_IDLE) tick_busy(nack_at);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_phase_q.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // write the device address; callers drain first
   task automatic write_dev_addr(input logic [7:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      dev_addr_q = v;
   endtask

   // ---------------------------------------------------------------- readiness

   initial begin
      @(negedge reset);
      forever begin
         int gap;
         gap = (rsp_gap_max > 0) ? $urandom_range(0, rsp_gap_max) : 0;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // ---------------------------------------------------------------- checking

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         bad_count++;
         if (bad_count <= 10)
            $display("mismatch beat %0d %s: expected %0h actual %0h",
                     rsp_seen, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      i2cram_pkg::rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_phase_q.size() == 0) begin
            bad_count++;
            if (bad_count <= 10)
               $display("unexpected result beat %0d: tdata %0h", rsp_seen, rsp_tdata);
         end else begin
            want = expected_phase_q.pop_front();
            check_field("scl_level", want.scl_level, rsp_tdata[0]);
            check_field("sda_level", want.sda_level, rsp_tdata[1]);
            check_field("busy_res",  want.busy_res,  rsp_tdata[2]);
            check_field("done_res",  want.done_res,  rsp_tdata[3]);
            check_field("success",   want.success,   rsp_tdata[4]);
            check_field("read_byte", want.read_byte, rsp_tdata[12:5]);
         end
         rsp_seen++;
      end
   end

   // ---------------------------------------------------------------- tests

   // idle ticks with field extremes; lines stay released
   task automatic test_idle_ticks();
      send_beat(i2cram_pkg::ACT_TICK,  8'h00, 8'h00, 1'b0);
      send_beat(i2cram_pkg::ACT_TICK,  8'hFF, 8'hFF, 1'b1);
      send_beat(ACT_SPARE, 8'h00, 8'hFF, 1'b1);
      send_beat(ACT_SPARE, 8'hFF, 8'h00, 1'b0);
      drain_results();
   endtask

   task automatic test_write_frames();
      run_frame(i2cram_pkg::ACT_WRITE, 8'h00, 8'hFF, PH_IDLE);
      run_frame(i2cram_pkg::ACT_WRITE, 8'hFF, 8'h00, PH_IDLE);
      drain_results();
   endtask

   task automatic test_read_frames();
      run_frame(i2cram_pkg::ACT_READ, 8'hFF, 8'h00, PH_IDLE);
      run_frame(i2cram_pkg::ACT_READ, 8'h00, 8'hFF, PH_IDLE);
      drain_results();
   endtask

   // refuse each acknowledge slot in turn, then idle on the held lines
   task automatic test_nack_every_slot();
      run_frame(i2cram_pkg::ACT_WRITE, 8'h12, 8'h34, PH_ACK_DEV_W);
      send_beat(i2cram_pkg::ACT_TICK, 8'h00, 8'h00, 1'b1);
      run_frame(i2cram_pkg::ACT_WRITE, 8'h56, 8'h78, PH_ACK_REG);
      run_frame(i2cram_pkg::ACT_WRITE, 8'h9A, 8'hBC, PH_ACK_DATA);
      send_beat(ACT_SPARE, 8'h00, 8'h00, 1'b0);
      run_frame(i2cram_pkg::ACT_READ, 8'hDE, 8'hF0, PH_ACK_REG);
      run_frame(i2cram_pkg::ACT_READ, 8'hA5, 8'h5A, PH_ACK_DEV_R);
      send_beat(i2cram_pkg::ACT_TICK, 8'h00, 8'h00, 1'b1);
      drain_results();
   endtask

   // odd address sent as is, read form wraps from all ones to zero
   task automatic test_address_edges();
      write_dev_addr(8'hFF);
      run_frame(i2cram_pkg::ACT_WRITE, 8'h3C, 8'hC3, PH_IDLE);
      run_frame(i2cram_pkg::ACT_READ, 8'h3C, 8'h00, PH_IDLE);
      drain_results();
      write_dev_addr(8'h00);
      run_frame(i2cram_pkg::ACT_READ, 8'h81, 8'h00, PH_IDLE);
      drain_results();
      write_dev_addr(8'hFE);
      run_frame(i2cram_pkg::ACT_WRITE, 8'h7E, 8'h81, PH_IDLE);
      drain_results();
   endtask

   // change the address between the register byte and the read address
   task automatic test_address_swap();
      write_dev_addr(8'h3C);
      send_beat(i2cram_pkg::ACT_READ, 8'h44, 8'h00, 1'b0);
      while (ph != PH_ACK_REG) tick_busy(PH_IDLE);
      drain_results();
      write_dev_addr(8'hC3);
      while (ph != PH_IDLE) tick_busy(PH_IDLE);
      drain_results();
      write_dev_addr(i2cram_pkg::DEV_ADDR_RESET);
   endtask

   task automatic test_random_traffic();
      int         start_cnt;
      int         pick;
      ph_type     nack_at;
      logic [1:0] act;
      start_cnt = beats_sent;
      while (beats_sent - start_cnt < 400) begin
         // alternate paced stretches with back-to-back stretches
         if ($urandom_range(0, 3) == 0) begin
            req_gap_max = 0;
            rsp_gap_max = 0;
         end else begin
            req_gap_max = GAP_MAX;
            rsp_gap_max = GAP_MAX;
         end
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            drain_results();
            case ($urandom_range(0, 3))
               0:       write_dev_addr(8'h00);
               1:       write_dev_addr(8'hFF);
               2:       write_dev_addr(i2cram_pkg::DEV_ADDR_RESET);
               default: write_dev_addr(8'($urandom_range(0, 255)));
            endcase
         end else if (pick < 18) begin
            repeat ($urandom_range(1, 6))
               send_beat($urandom_range(0, 1) ? ACT_SPARE : i2cram_pkg::ACT_TICK,
                         8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)));
         end else begin
            act = $urandom_range(0, 1) ? i2cram_pkg::ACT_WRITE : i2cram_pkg::ACT_READ;
            nack_at = PH_IDLE;
            noise_pct = 0;
            case ($urandom_range(0, 9))
               0: case ($urandom_range(0, 2))
                     0:       nack_at = PH_ACK_DEV_W;
                     1:       nack_at = PH_ACK_REG;
                     default: nack_at = (act == i2cram_pkg::ACT_WRITE) ?
                                        PH_ACK_DATA : PH_ACK_DEV_R;
                  endcase
               1: noise_pct = 10;
               default: ;
            endcase
            run_frame(act, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      nack_at);
            noise_pct = 0;
         end
      end
      req_gap_max = GAP_MAX;
      rsp_gap_max = GAP_MAX;
      drain_results();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_ticks();
      test_write_frames();
      test_read_frames();
      test_nack_every_slot();
      test_address_edges();
      test_address_swap();
      test_random_traffic();
      drain_results();
      if (bad_count == 0 && expected_phase_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
